[hdl/ttce_pkg.sv]
// Text console character engine: shared types, codes and constants.
// Used by every module of the block but ttce_ram; depends on nothing.

package ttce_pkg;

    // Default screen geometry
    localparam int DEF_COLUMNS = 80;
    localparam int DEF_ROWS    = 25;

    // Port field widths
    localparam int OPC_W   = 2;
    localparam int CHAR_W  = 8;
    localparam int POSC_W  = 7;
    localparam int POSR_W  = 5;
    localparam int CELL_W  = 16;
    localparam int COLR_W  = 4;

    // Character codes with a meaning of their own
    localparam logic [CHAR_W-1:0] CH_BS    = 8'h08;
    localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;

    // Attribute after reset and the blank cell that goes with it
    localparam logic [7:0]        RESET_ATTR  = 8'h07;
    localparam logic [CELL_W-1:0] RESET_BLANK = {RESET_ATTR, CH_SPACE};
    localparam logic [COLR_W-1:0] RESET_FORE  = 4'h7;
    localparam logic [COLR_W-1:0] RESET_BACK  = 4'h0;

    // Tab stops every eight columns
    localparam int TAB_STEP = 8;

    typedef enum logic [OPC_W-1:0] {
        OP_PUT    = 2'd0,
        OP_CLEAR  = 2'd1,
        OP_SETPOS = 2'd2,
        OP_READ   = 2'd3
    } t_opcode;

    typedef enum logic [0:0] {
        CFG_FORE = 1'b0,
        CFG_BACK = 1'b1
    } t_cfg_idx;

    // Classified command kinds
    typedef enum logic [2:0] {
        K_WRITE,
        K_NEWLINE,
        K_RETURN,
        K_BACKSPACE,
        K_TAB,
        K_CLEAR,
        K_SETPOS,
        K_READ
    } t_kind;

    typedef struct packed {
        t_kind              kind;
        logic [CHAR_W-1:0]  ch;
        logic [POSC_W-1:0]  col;
        logic [POSR_W-1:0]  row;
        logic               in_range;
    } t_cmd;

    typedef struct packed {
        logic [POSC_W-1:0] col;
        logic [POSR_W-1:0] row;
        logic [CELL_W-1:0] cell_data;
        logic              scroll;
    } t_result;

    typedef enum logic [1:0] {
        ST_FILL,
        ST_IDLE,
        ST_READ
    } t_state;

endpackage

[hdl/ttce_ram.sv]
// Generic single-port RAM with registered read data.
// No dependencies.

module ttce_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write, or read into the output register
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end else begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[hdl/ttce_front.sv]
// Front end: accepts input transactions, classifies them into commands
// and holds them in a two-entry queue for the back end. Uses ttce_pkg.

module ttce_front #(
    parameter int COLUMNS = ttce_pkg::DEF_COLUMNS,
    parameter int ROWS    = ttce_pkg::DEF_ROWS
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_hold,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [ttce_pkg::OPC_W-1:0]  i_opcode,
    input  logic [ttce_pkg::CHAR_W-1:0] i_char_code,
    input  logic [ttce_pkg::POSC_W-1:0] i_pos_col,
    input  logic [ttce_pkg::POSR_W-1:0] i_pos_row,
    output logic                        o_cmd_valid,
    output ttce_pkg::t_cmd              o_cmd,
    input  logic                        i_cmd_pop
);

    ttce_pkg::t_cmd r_q [2];
    logic           r_wptr;
    logic           r_rptr;
    logic [1:0]     r_count;
    logic [1:0]     n_count;
    ttce_pkg::t_cmd cls;
    logic           push;

    // classify the incoming item
    always_comb begin
        cls.ch       = i_char_code;
        cls.col      = i_pos_col;
        cls.row      = i_pos_row;
        cls.in_range = ({1'b0, i_pos_col} < (ttce_pkg::POSC_W+1)'(COLUMNS)) &&
                       ({1'b0, i_pos_row} < (ttce_pkg::POSR_W+1)'(ROWS));
        unique case (ttce_pkg::t_opcode'(i_opcode))
            ttce_pkg::OP_PUT: begin
                unique case (i_char_code)
                    ttce_pkg::CH_LF:  cls.kind = ttce_pkg::K_NEWLINE;
                    ttce_pkg::CH_CR:  cls.kind = ttce_pkg::K_RETURN;
                    ttce_pkg::CH_BS:  cls.kind = ttce_pkg::K_BACKSPACE;
                    ttce_pkg::CH_TAB: cls.kind = ttce_pkg::K_TAB;
                    default:          cls.kind = ttce_pkg::K_WRITE;
                endcase
            end
            ttce_pkg::OP_CLEAR:  cls.kind = ttce_pkg::K_CLEAR;
            ttce_pkg::OP_SETPOS: cls.kind = ttce_pkg::K_SETPOS;
            ttce_pkg::OP_READ:   cls.kind = ttce_pkg::K_READ;
            default:             cls.kind = ttce_pkg::K_READ;
        endcase
    end

    assign o_in_ready  = (r_count != 2'd2) && !i_hold;
    assign push        = i_in_valid && o_in_ready;
    assign o_cmd_valid = (r_count != 2'd0);
    assign o_cmd       = r_q[r_rptr];

    always_comb begin
        n_count = r_count;
        if (push && !i_cmd_pop) begin
            n_count = r_count + 2'd1;
        end else if (!push && i_cmd_pop) begin
            n_count = r_count - 2'd1;
        end
    end

    // queue storage
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wptr] <= cls;
        end
    end

    // queue pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (push) begin
                r_wptr <= ~r_wptr;
            end
            if (i_cmd_pop) begin
                r_rptr <= ~r_rptr;
            end
            r_count <= n_count;
        end
    end

endmodule

[hdl/ttce_back.sv]
// Back end: runs commands against the screen store, keeps the cursor,
// colour registers, row offset and result register. Uses ttce_pkg, ttce_ram.

module ttce_back #(
    parameter int COLUMNS = ttce_pkg::DEF_COLUMNS,
    parameter int ROWS    = ttce_pkg::DEF_ROWS
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic                        i_cfg_index,
    input  logic [ttce_pkg::COLR_W-1:0] i_cfg_data,
    input  logic                        i_cmd_valid,
    input  ttce_pkg::t_cmd              i_cmd,
    output logic                        o_cmd_pop,
    output logic                        o_init,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output ttce_pkg::t_result           o_res
);

    localparam int COL_W  = $clog2(COLUMNS);
    localparam int ROW_W  = $clog2(ROWS);
    localparam int ADDR_W = ROW_W + COL_W;
    localparam logic [COL_W-1:0] COL_LAST = COL_W'(COLUMNS - 1);
    localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(ROWS - 1);

    ttce_pkg::t_state  r_state, n_state;
    logic              r_init, n_init;
    logic [COL_W-1:0]  r_cur_col, n_cur_col;
    logic [ROW_W-1:0]  r_cur_row, n_cur_row;
    logic [ROW_W-1:0]  r_base, n_base;
    logic [ROW_W-1:0]  r_fill_row, n_fill_row;
    logic [ROW_W-1:0]  r_fill_last, n_fill_last;
    logic [COL_W-1:0]  r_fill_col, n_fill_col;
    logic [ttce_pkg::CELL_W-1:0] r_fill_data, n_fill_data;
    logic              r_scroll, n_scroll;
    logic              r_out_valid, n_out_valid;
    ttce_pkg::t_result r_res, n_res;
    logic [ttce_pkg::COLR_W-1:0] r_fore, r_back;

    logic                        ram_we;
    logic [ADDR_W-1:0]           ram_addr;
    logic [ttce_pkg::CELL_W-1:0] ram_wdata;
    logic [ttce_pkg::CELL_W-1:0] ram_rdata;

    logic [7:0]                  attr;
    logic [ttce_pkg::CELL_W-1:0] blank;
    logic [ROW_W-1:0]            cur_phys;
    logic [ROW_W-1:0]            rd_phys;
    logic [ROW_W-1:0]            base_inc;
    logic [COL_W-1:0]            bs_col;
    logic [COL_W:0]              tab_sum;
    logic [COL_W:0]              tab_col;
    logic                        out_free;
    logic                        nl;
    logic                        done_now;

    // logical row to physical row through the scroll offset
    function automatic logic [ROW_W-1:0] phys_row(input logic [ROW_W-1:0] row,
                                                  input logic [ROW_W-1:0] base);
        logic [ROW_W:0] sum;
        sum = {1'b0, row} + {1'b0, base};
        if (sum >= (ROW_W+1)'(ROWS)) begin
            sum = sum - (ROW_W+1)'(ROWS);
        end
        return sum[ROW_W-1:0];
    endfunction

    ttce_ram #(
        .WIDTH (ttce_pkg::CELL_W),
        .DEPTH (2 ** ADDR_W)
    ) u_screen (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );

    assign attr     = {r_back, r_fore};
    assign blank    = {attr, ttce_pkg::CH_SPACE};
    assign cur_phys = phys_row(r_cur_row, r_base);
    assign rd_phys  = phys_row(i_cmd.row[ROW_W-1:0], r_base);
    assign base_inc = (r_base == ROW_LAST) ? '0 : r_base + 1'b1;
    assign bs_col   = (r_cur_col == '0) ? '0 : r_cur_col - 1'b1;
    assign tab_sum  = {1'b0, r_cur_col} + (COL_W+1)'(ttce_pkg::TAB_STEP);
    assign tab_col  = {tab_sum[COL_W:3], 3'b000};
    assign out_free = !r_out_valid || i_out_ready;

    // next state, cursor and store access
    always_comb begin
        n_state     = r_state;
        n_init      = r_init;
        n_cur_col   = r_cur_col;
        n_cur_row   = r_cur_row;
        n_base      = r_base;
        n_fill_row  = r_fill_row;
        n_fill_last = r_fill_last;
        n_fill_col  = r_fill_col;
        n_fill_data = r_fill_data;
        n_scroll    = r_scroll;
        n_out_valid = r_out_valid && !i_out_ready;
        n_res       = r_res;
        ram_we      = 1'b0;
        ram_addr    = {cur_phys, r_cur_col};
        ram_wdata   = blank;
        o_cmd_pop   = 1'b0;
        nl          = 1'b0;
        done_now    = 1'b0;

        unique case (r_state)
            // blanking sweep: reset pass, clear screen or scrolled row
            ttce_pkg::ST_FILL: begin
                ram_we    = 1'b1;
                ram_addr  = {r_fill_row, r_fill_col};
                ram_wdata = r_fill_data;
                if (r_fill_col == COL_LAST) begin
                    n_fill_col = '0;
                    if (r_fill_row == r_fill_last) begin
                        n_state = ttce_pkg::ST_IDLE;
                        n_init  = 1'b0;
                        if (!r_init) begin
                            n_out_valid = 1'b1;
                            n_res.col   = ttce_pkg::POSC_W'(r_cur_col);
                            n_res.row   = ttce_pkg::POSR_W'(r_cur_row);
                            n_res.cell_data = '0;
                            n_res.scroll = r_scroll;
                        end
                    end else begin
                        n_fill_row = r_fill_row + 1'b1;
                    end
                end else begin
                    n_fill_col = r_fill_col + 1'b1;
                end
            end

            ttce_pkg::ST_IDLE: begin
                if (i_cmd_valid && out_free) begin
                    o_cmd_pop = 1'b1;
                    done_now  = 1'b1;
                    n_scroll  = 1'b0;
                    unique case (i_cmd.kind)
                        ttce_pkg::K_WRITE: begin
                            ram_we    = 1'b1;
                            ram_wdata = {attr, i_cmd.ch};
                            if (r_cur_col == COL_LAST) begin
                                nl = 1'b1;
                            end else begin
                                n_cur_col = r_cur_col + 1'b1;
                            end
                        end
                        ttce_pkg::K_NEWLINE: nl = 1'b1;
                        ttce_pkg::K_RETURN:  n_cur_col = '0;
                        ttce_pkg::K_BACKSPACE: begin
                            n_cur_col = bs_col;
                            ram_we    = 1'b1;
                            ram_addr  = {cur_phys, bs_col};
                        end
                        ttce_pkg::K_TAB: begin
                            if (tab_col >= (COL_W+1)'(COLUMNS)) begin
                                nl = 1'b1;
                            end else begin
                                n_cur_col = tab_col[COL_W-1:0];
                            end
                        end
                        ttce_pkg::K_CLEAR: begin
                            n_cur_col   = '0;
                            n_cur_row   = '0;
                            n_base      = '0;
                            n_fill_row  = '0;
                            n_fill_col  = '0;
                            n_fill_last = ROW_LAST;
                            n_fill_data = blank;
                            n_state     = ttce_pkg::ST_FILL;
                            done_now    = 1'b0;
                        end
                        ttce_pkg::K_SETPOS: begin
                            if (i_cmd.in_range) begin
                                n_cur_col = i_cmd.col[COL_W-1:0];
                                n_cur_row = i_cmd.row[ROW_W-1:0];
                            end
                        end
                        ttce_pkg::K_READ: begin
                            if (i_cmd.in_range) begin
                                ram_addr = {rd_phys, i_cmd.col[COL_W-1:0]};
                                n_state  = ttce_pkg::ST_READ;
                                done_now = 1'b0;
                            end
                        end
                        default: ;
                    endcase

                    // next line, scrolling through the row offset
                    if (nl) begin
                        n_cur_col = '0;
                        if (r_cur_row == ROW_LAST) begin
                            n_base      = base_inc;
                            n_fill_row  = r_base;
                            n_fill_last = r_base;
                            n_fill_col  = '0;
                            n_fill_data = blank;
                            n_scroll    = 1'b1;
                            n_state     = ttce_pkg::ST_FILL;
                            done_now    = 1'b0;
                        end else begin
                            n_cur_row = r_cur_row + 1'b1;
                        end
                    end

                    if (done_now) begin
                        n_out_valid  = 1'b1;
                        n_res.col    = ttce_pkg::POSC_W'(n_cur_col);
                        n_res.row    = ttce_pkg::POSR_W'(n_cur_row);
                        n_res.cell_data = '0;
                        n_res.scroll = 1'b0;
                    end
                end
            end

            // read data arrives in the cycle after the address
            ttce_pkg::ST_READ: begin
                n_state      = ttce_pkg::ST_IDLE;
                n_out_valid  = 1'b1;
                n_res.col    = ttce_pkg::POSC_W'(r_cur_col);
                n_res.row    = ttce_pkg::POSR_W'(r_cur_row);
                n_res.cell_data = ram_rdata;
                n_res.scroll = 1'b0;
            end

            default: n_state = ttce_pkg::ST_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ttce_pkg::ST_FILL;
            r_init      <= 1'b1;
            r_cur_col   <= '0;
            r_cur_row   <= '0;
            r_base      <= '0;
            r_fill_row  <= '0;
            r_fill_last <= ROW_LAST;
            r_fill_col  <= '0;
            r_fill_data <= ttce_pkg::RESET_BLANK;
            r_scroll    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_init      <= n_init;
            r_cur_col   <= n_cur_col;
            r_cur_row   <= n_cur_row;
            r_base      <= n_base;
            r_fill_row  <= n_fill_row;
            r_fill_last <= n_fill_last;
            r_fill_col  <= n_fill_col;
            r_fill_data <= n_fill_data;
            r_scroll    <= n_scroll;
            r_out_valid <= n_out_valid;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        r_res <= n_res;
    end

    // colour registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fore <= ttce_pkg::RESET_FORE;
            r_back <= ttce_pkg::RESET_BACK;
        end else if (i_cfg_we) begin
            unique case (ttce_pkg::t_cfg_idx'(i_cfg_index))
                ttce_pkg::CFG_FORE: r_fore <= i_cfg_data;
                ttce_pkg::CFG_BACK: r_back <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_init      = r_init;
    assign o_out_valid = r_out_valid;
    assign o_res       = r_res;

    // cursor and row offset stay on the screen
    a_cursor_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (32'(r_cur_col) < COLUMNS) && (32'(r_cur_row) < ROWS) && (32'(r_base) < ROWS))
        else $error("cursor or row offset off screen");

    // a read always delivers its result on the next cycle
    a_read_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ttce_pkg::ST_READ) |=> r_out_valid)
        else $error("read cell result missing");

    // no command leaves the queue during the reset blanking pass
    a_init_no_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_init |-> !o_cmd_pop)
        else $error("command taken during reset blanking");

    // a scrolled result leaves the cursor on the bottom row
    a_scroll_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_res.scroll) |-> (32'(r_res.row) == ROWS - 1))
        else $error("scroll reported away from bottom row");

endmodule

[hdl/text_console_character_engine.sv]
// Text console character engine top level: front end, command queue, back end.
// Depends on ttce_pkg, ttce_front, ttce_back, ttce_ram.
//
//  channel  direction  handshake              payload
//  -------  ---------  ---------------------  ------------------------------------------
//  in       input      i_in_valid/o_in_ready  i_opcode i_char_code i_pos_col i_pos_row
//  out      output     o_out_valid/i_out_ready o_cur_col o_cur_row o_cell_value o_did_scroll
//  cfg      input      i_cfg_we               i_cfg_index i_cfg_data
//
// Most commands are done in a single back-end state; a transaction's result is registered
// after its command leaves the queue. Read cell also takes the ST_READ state (registered
// store read). A scroll blanks one row and clear screen blanks all before their result.
// After reset a blanking pass over the whole screen runs with input ready low.
// A two-entry queue keeps accepting, until full, while a clear or scroll sweeps or the output stalls.

module text_console_character_engine #(
    parameter int COLUMNS = ttce_pkg::DEF_COLUMNS,
    parameter int ROWS    = ttce_pkg::DEF_ROWS
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic                        i_cfg_index,
    input  logic [ttce_pkg::COLR_W-1:0] i_cfg_data,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [ttce_pkg::OPC_W-1:0]  i_opcode,
    input  logic [ttce_pkg::CHAR_W-1:0] i_char_code,
    input  logic [ttce_pkg::POSC_W-1:0] i_pos_col,
    input  logic [ttce_pkg::POSR_W-1:0] i_pos_row,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [ttce_pkg::POSC_W-1:0] o_cur_col,
    output logic [ttce_pkg::POSR_W-1:0] o_cur_row,
    output logic [ttce_pkg::CELL_W-1:0] o_cell_value,
    output logic                        o_did_scroll
);

    logic              cmd_valid;
    ttce_pkg::t_cmd    cmd;
    logic              cmd_pop;
    logic              init;
    ttce_pkg::t_result res;

    ttce_front #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_hold      (init),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_opcode    (i_opcode),
        .i_char_code (i_char_code),
        .i_pos_col   (i_pos_col),
        .i_pos_row   (i_pos_row),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd),
        .i_cmd_pop   (cmd_pop)
    );

    ttce_back #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_pop   (cmd_pop),
        .o_init      (init),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_res       (res)
    );

    // result fields out to their ports
    assign o_cur_col    = res.col;
    assign o_cur_row    = res.row;
    assign o_cell_value = res.cell_data;
    assign o_did_scroll = res.scroll;

endmodule

[dv/tb_text_console_character_engine.sv]
// Testbench for the text console character engine: random and directed commands,
// a shadow screen and cursor that predict every status transaction, field by field.
// Depends on ttce_pkg and text_console_character_engine.

module tb_text_console_character_engine;

    import ttce_pkg::*;

    localparam int COLS           = DEF_COLUMNS;
    localparam int ROWS_N         = DEF_ROWS;
    localparam int PHASES         = 6;
    localparam int PHASE_CMDS     = 287;
    localparam int CFG_SETTLE     = DEF_COLUMNS * DEF_ROWS + 100;
    localparam int TAIL_CYCLES    = 200;
    localparam int HOLD_AFTER     = 400;
    localparam int HOLD_LEN       = 400;
    localparam int WATCHDOG_LIMIT = 30000;

    typedef struct packed {
        t_opcode           op;
        logic [CHAR_W-1:0] ch;
        logic [POSC_W-1:0] col;
        logic [POSR_W-1:0] row;
    } t_console_cmd;

    // DUT ports; the inputs are all known from time zero
    logic                i_clk       = 1'b0;
    logic                i_rst_n     = 1'b0;
    logic                i_cfg_we    = 1'b0;
    logic                i_cfg_index = 1'b0;
    logic [COLR_W-1:0]   i_cfg_data  = '0;
    logic                i_in_valid  = 1'b0;
    logic                o_in_ready;
    logic [OPC_W-1:0]    i_opcode    = '0;
    logic [CHAR_W-1:0]   i_char_code = '0;
    logic [POSC_W-1:0]   i_pos_col   = '0;
    logic [POSR_W-1:0]   i_pos_row   = '0;
    logic                o_out_valid;
    logic                i_out_ready = 1'b0;
    logic [POSC_W-1:0]   o_cur_col;
    logic [POSR_W-1:0]   o_cur_row;
    logic [CELL_W-1:0]   o_cell_value;
    logic                o_did_scroll;

    // Shadow of the console state
    logic [CELL_W-1:0]   shadow_screen [0:COLS*ROWS_N-1];
    int unsigned         crs_col;
    int unsigned         crs_row;
    logic [COLR_W-1:0]   fore_c;
    logic [COLR_W-1:0]   back_c;

    // Stimulus and scoreboard
    t_console_cmd        cmd_backlog [$];
    t_result             status_due [$];
    int unsigned         n_issued   = 0;
    int unsigned         n_accepted = 0;
    int unsigned         n_checked  = 0;
    int unsigned         n_errors   = 0;
    int unsigned         n_scrolls  = 0;
    int unsigned         n_clears   = 0;
    int unsigned         src_idle_pct = 20;
    int unsigned         snk_idle_pct = 20;
    logic                in_taken = 1'b0;

    text_console_character_engine #(
        .COLUMNS (COLS),
        .ROWS    (ROWS_N)
    ) DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_opcode     (i_opcode),
        .i_char_code  (i_char_code),
        .i_pos_col    (i_pos_col),
        .i_pos_row    (i_pos_row),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_cur_col    (o_cur_col),
        .o_cur_row    (o_cur_row),
        .o_cell_value (o_cell_value),
        .o_did_scroll (o_did_scroll)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Console prediction
    // ------------------------------------------------------------------
    function automatic logic [CELL_W-1:0] cell_of(logic [CHAR_W-1:0] ch);
        return {back_c, fore_c, ch};
    endfunction

    // Move to column 0 of the next row; scroll up when past the bottom
    function automatic logic next_row();
        int unsigned i;
        crs_col = 0;
        crs_row = crs_row + 1;
        if (crs_row < ROWS_N) return 1'b0;
        for (i = 0; i < COLS * (ROWS_N - 1); i++) shadow_screen[i] = shadow_screen[i + COLS];
        for (i = COLS * (ROWS_N - 1); i < COLS * ROWS_N; i++) shadow_screen[i] = cell_of(CH_SPACE);
        crs_row = ROWS_N - 1;
        return 1'b1;
    endfunction

    function automatic t_result console_step(t_console_cmd c);
        t_result     r;
        logic        sc;
        int unsigned i;
        r  = '0;
        sc = 1'b0;
        case (c.op)
            OP_PUT: begin
                case (c.ch)
                    CH_LF: sc = next_row();
                    CH_CR: crs_col = 0;
                    CH_BS: begin
                        if (crs_col > 0) crs_col = crs_col - 1;
                        shadow_screen[crs_row * COLS + crs_col] = cell_of(CH_SPACE);
                    end
                    CH_TAB: begin
                        crs_col = (crs_col + TAB_STEP) & ~(TAB_STEP - 1);
                        if (crs_col >= COLS) sc = next_row();
                    end
                    default: begin
                        shadow_screen[crs_row * COLS + crs_col] = cell_of(c.ch);
                        crs_col = crs_col + 1;
                        if (crs_col >= COLS) sc = next_row();
                    end
                endcase
            end
            OP_CLEAR: begin
                for (i = 0; i < COLS * ROWS_N; i++) shadow_screen[i] = cell_of(CH_SPACE);
                crs_col = 0;
                crs_row = 0;
            end
            OP_SETPOS: begin
                // out-of-range positions leave the cursor alone
                if (c.col < COLS && c.row < ROWS_N) begin
                    crs_col = 32'(c.col);
                    crs_row = 32'(c.row);
                end
            end
            default: begin
                if (c.col < COLS && c.row < ROWS_N)
                    r.cell_data = shadow_screen[c.row * COLS + c.col];
            end
        endcase
        r.col    = POSC_W'(crs_col);
        r.row    = POSR_W'(crs_row);
        r.scroll = sc;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic queue_cmd(t_opcode op, logic [CHAR_W-1:0] ch,
                             logic [POSC_W-1:0] col, logic [POSR_W-1:0] row);
        cmd_backlog.push_back('{op: op, ch: ch, col: col, row: row});
        n_issued++;
    endtask

    // Mostly character writes of random byte codes; positions lean to the bottom row to provoke scrolls
    function automatic t_console_cmd random_command();
        t_console_cmd c;
        int unsigned  pick;
        c.ch  = CHAR_W'($urandom);
        c.col = POSC_W'($urandom);
        c.row = POSR_W'($urandom);
        if ($urandom_range(0, 5) != 0) begin
            c.col = POSC_W'($urandom_range(0, COLS - 1));
            c.row = ($urandom_range(0, 3) == 0) ? POSR_W'(ROWS_N - 1)
                                                : POSR_W'($urandom_range(0, ROWS_N - 1));
        end
        pick = $urandom_range(0, 999);
        if (pick < 8) begin
            c.op = OP_CLEAR;
        end else if (pick < 130) begin
            c.op = OP_SETPOS;
        end else if (pick < 300) begin
            c.op = OP_READ;
        end else begin
            c.op = OP_PUT;
            case ($urandom_range(0, 11))
                0: c.ch = CH_LF;
                1: c.ch = CH_CR;
                2: c.ch = CH_BS;
                3: c.ch = CH_TAB;
                default: ;
            endcase
        end
        return c;
    endfunction

    task automatic write_colour(t_cfg_idx idx, logic [COLR_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        if (idx == CFG_FORE) fore_c = val;
        else back_c = val;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        i_cfg_index <= 1'($urandom);
        i_cfg_data  <= COLR_W'($urandom);
    endtask

    // Wait until every command is in and answered, then let any sweep finish
    task automatic wait_drained(int unsigned settle);
        wait (n_accepted == n_issued && status_due.size() == 0);
        repeat (settle) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Sequence: reset, directed commands, then random phases per colour setting
    // ------------------------------------------------------------------
    initial begin
        logic [COLR_W-1:0] fore_plan [PHASES];
        logic [COLR_W-1:0] back_plan [PHASES];
        int unsigned       src_plan  [PHASES];
        int unsigned       snk_plan  [PHASES];
        int unsigned       i;
        int unsigned       ph;

        for (i = 0; i < COLS * ROWS_N; i++) shadow_screen[i] = RESET_BLANK;
        fore_c  = RESET_FORE;
        back_c  = RESET_BACK;
        crs_col = 0;
        crs_row = 0;

        fore_plan = '{4'hF, 4'h0, 4'hF, 4'h0, COLR_W'($urandom), COLR_W'($urandom)};
        back_plan = '{4'hF, 4'h0, 4'h0, 4'hF, COLR_W'($urandom), COLR_W'($urandom)};
        src_plan  = '{25, 0, 40, 10, 15, 0};
        snk_plan  = '{10, 30, 0, 40, 15, 0};

        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset contents, backspace at column 0, tab, wrap, ignored positions
        queue_cmd(OP_READ,   8'h00,  7'd0,   5'd0);
        queue_cmd(OP_PUT,    8'h41,  7'd127, 5'd31);
        queue_cmd(OP_READ,   8'hFF,  7'd0,   5'd0);
        queue_cmd(OP_PUT,    CH_BS,  7'd0,   5'd0);
        queue_cmd(OP_PUT,    CH_BS,  7'd0,   5'd0);
        queue_cmd(OP_READ,   8'h00,  7'd0,   5'd0);
        queue_cmd(OP_PUT,    CH_TAB, 7'd0,   5'd0);
        queue_cmd(OP_PUT,    8'hFF,  7'd0,   5'd0);
        queue_cmd(OP_SETPOS, 8'h00,  7'd79,  5'd0);
        queue_cmd(OP_PUT,    8'h00,  7'd0,   5'd0);
        queue_cmd(OP_READ,   8'h00,  7'd79,  5'd0);
        queue_cmd(OP_SETPOS, 8'h00,  7'd75,  5'd3);
        queue_cmd(OP_PUT,    CH_TAB, 7'd0,   5'd0);
        queue_cmd(OP_SETPOS, 8'h00,  7'd40,  5'd5);
        queue_cmd(OP_PUT,    CH_CR,  7'd0,   5'd0);
        queue_cmd(OP_SETPOS, 8'h00,  7'd80,  5'd0);
        queue_cmd(OP_SETPOS, 8'h00,  7'd0,   5'd25);
        queue_cmd(OP_SETPOS, 8'hFF,  7'd127, 5'd31);
        queue_cmd(OP_READ,   8'h00,  7'd80,  5'd0);
        queue_cmd(OP_READ,   8'h00,  7'd0,   5'd31);
        // scrolls by wrap, line feed and tab on the bottom row
        queue_cmd(OP_SETPOS, 8'h00,  7'd79,  5'd24);
        queue_cmd(OP_PUT,    8'h7E,  7'd0,   5'd0);
        queue_cmd(OP_PUT,    CH_LF,  7'd0,   5'd0);
        queue_cmd(OP_READ,   8'h00,  7'd79,  5'd22);
        queue_cmd(OP_SETPOS, 8'h00,  7'd79,  5'd24);
        queue_cmd(OP_PUT,    CH_TAB, 7'd0,   5'd0);
        queue_cmd(OP_CLEAR,  8'hFF,  7'd127, 5'd31);
        queue_cmd(OP_READ,   8'h00,  7'd79,  5'd24);
        wait_drained(CFG_SETTLE);

        for (ph = 0; ph < PHASES; ph++) begin
            write_colour(CFG_FORE, fore_plan[ph]);
            write_colour(CFG_BACK, back_plan[ph]);
            @(posedge i_clk);
            src_idle_pct = src_plan[ph];
            snk_idle_pct = snk_plan[ph];
            for (i = 0; i < PHASE_CMDS; i++) begin
                cmd_backlog.push_back(random_command());
                n_issued++;
            end
            wait_drained((ph == PHASES - 1) ? TAIL_CYCLES : CFG_SETTLE);
        end

        $display("%0d commands checked: %0d scrolls, %0d screen clears, %0d colour settings",
                 n_checked, n_scrolls, n_clears, PHASES + 1);
        if (n_errors == 0) begin
            $display("PASS text_console_character_engine");
        end else begin
            $display("FAIL text_console_character_engine");
        end
        $finish;
    end

    // ------------------------------------------------------------------
    // Command driver: valid holds until the transaction is taken
    // ------------------------------------------------------------------
    t_console_cmd offer;
    logic         offering = 1'b0;
    int unsigned  src_gap  = 0;

    always @(negedge i_clk) begin
        if (in_taken) offering = 1'b0;
        if (i_rst_n && !offering) begin
            if (src_gap == 0 && $urandom_range(0, 99) < src_idle_pct)
                src_gap = $urandom_range(1, 10);
            if (src_gap != 0) begin
                src_gap--;
            end else if (cmd_backlog.size() != 0) begin
                offer    = cmd_backlog.pop_front();
                offering = 1'b1;
            end
        end
        i_in_valid <= offering;
        if (offering) begin
            i_opcode    <= offer.op;
            i_char_code <= offer.ch;
            i_pos_col   <= offer.col;
            i_pos_row   <= offer.row;
        end else begin
            i_opcode    <= OPC_W'($urandom);
            i_char_code <= CHAR_W'($urandom);
            i_pos_col   <= POSC_W'($urandom);
            i_pos_row   <= POSR_W'($urandom);
        end
    end

    // ------------------------------------------------------------------
    // Status receiver: random stall bursts plus one long hold-off
    // ------------------------------------------------------------------
    int unsigned snk_gap   = 0;
    int unsigned hold_left = 0;
    logic        hold_done = 1'b0;

    always @(negedge i_clk) begin
        if (!hold_done && n_checked >= HOLD_AFTER) begin
            hold_left = HOLD_LEN;
            hold_done = 1'b1;
        end
        if (hold_left == 0 && snk_gap == 0 && $urandom_range(0, 99) < snk_idle_pct)
            snk_gap = $urandom_range(1, 10);
        if (hold_left != 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else if (snk_gap != 0) begin
            snk_gap--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Monitor: predict on each command transaction, check each status one
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_result want;
        t_result got;
        in_taken <= i_rst_n && i_in_valid && o_in_ready;
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                want = console_step('{op: t_opcode'(i_opcode), ch: i_char_code,
                                      col: i_pos_col, row: i_pos_row});
                status_due.push_back(want);
                n_accepted++;
                if (want.scroll) n_scrolls++;
                if (t_opcode'(i_opcode) == OP_CLEAR) n_clears++;
            end
            if (o_out_valid && i_out_ready) begin
                got = {o_cur_col, o_cur_row, o_cell_value, o_did_scroll};
                if (status_due.size() == 0) begin
                    $display("%0t: status transaction with none expected (got %h)", $time, got);
                    n_errors++;
                end else begin
                    want = status_due.pop_front();
                    n_checked++;
                    if (got.col != want.col) begin
                        $display("%0t: cursor column expected %0d, got %0d",
                                 $time, want.col, got.col);
                        n_errors++;
                    end
                    if (got.row != want.row) begin
                        $display("%0t: cursor row expected %0d, got %0d",
                                 $time, want.row, got.row);
                        n_errors++;
                    end
                    if (got.cell_data != want.cell_data) begin
                        $display("%0t: cell value expected %h, got %h",
                                 $time, want.cell_data, got.cell_data);
                        n_errors++;
                    end
                    if (got.scroll != want.scroll) begin
                        $display("%0t: scroll flag expected %b, got %b",
                                 $time, want.scroll, got.scroll);
                        n_errors++;
                    end
                end
            end
        end
    end

    // Watchdog: too long without any transaction on either channel
    int unsigned quiet_cycles = 0;

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no transaction for %0d cycles, %0d results outstanding",
                     $time, quiet_cycles, status_due.size());
            $display("FAIL text_console_character_engine");
            $finish;
        end
    end

endmodule
